>>> rtl/asacu_pkg.sv
`default_nettype none

package asacu_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 16;

    // Q1.30 datapath types
    typedef logic        [30:0] t_q30;
    typedef logic signed [32:0] t_acc;
    typedef logic        [62:0] t_prd;
    typedef logic        [33:0] t_rem;
    typedef logic signed [34:0] t_ang;

    localparam logic OP_ASIN = 1'b0;
    localparam logic OP_ACOS = 1'b1;

    localparam t_q30 Q30_ONE     = 31'h4000_0000;
    localparam t_ang Q30_HALF_PI = 35'sd1686629713;
    localparam t_ang Q30_PI      = 35'sd3373259426;

    localparam int POLY_TERMS = 8;

    // minimax coefficients, highest degree first
    localparam t_acc COEF [0:POLY_TERMS-1] = '{
        -33'sd1355589,   33'sd7161955,   -33'sd18348235, 33'sd33169905,
        -33'sd53874249,  33'sd95540460,  -33'sd230423709, 33'sd1686629690
    };

    localparam int OUT_SHIFT = 33 - OUT_WIDTH;

endpackage

`default_nettype wire

>>> rtl/asacu_req_if.sv
`default_nettype none

interface asacu_req_if;
    import asacu_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       op;
    logic signed [IN_WIDTH-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/asacu_rsp_if.sv
`default_nettype none

interface asacu_rsp_if;
    import asacu_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

>>> rtl/arcsine_arccosine_unit_core.sv
// throughput: one request per cycle, unless back-pressure on o_rsp.ready holds the pipe
// 19 register stages, each a valid bit plus data
// stages: operand fold, 7 horner steps of multiply then round and add (sqrt runs beside them),
// multiply by the root, reflection, output rounding and saturation
// i_rst_n is synchronous, active low, and clears only the stage valid bits
`default_nettype none

module arcsine_arccosine_unit_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    asacu_req_if.sink   i_req,
    asacu_rsp_if.source o_rsp
);
    import asacu_pkg::*;

    localparam int LAST      = 18;  // output register stage
    localparam int SQ_STAGES = 11;  // stages 1..11 each run three sqrt iterations
    localparam int SQ_ITERS  = 3;
    localparam int ROOT_LAST = 14;  // root is read by the final multiply in stage 15

    localparam logic [OUT_WIDTH-1:0] LIM_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] LIM_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};
    localparam logic signed [OUT_WIDTH-1:0] ANGLE_MIN = -16'sd12868;
    localparam logic signed [OUT_WIDTH-1:0] ANGLE_MAX = 16'sd25736;

    // pipeline control
    logic [LAST:0] r_vld;
    logic [LAST:0] w_en;

    // stage payload
    logic        r_op  [0:LAST-1];
    logic        r_neg [0:LAST-1];
    t_q30        r_xp  [0:12];
    t_q30        r_omx [0:SQ_STAGES-1];
    t_rem        r_rem [1:SQ_STAGES-1];
    t_q30        r_root[1:ROOT_LAST];
    t_prd        r_prd [1:POLY_TERMS];
    logic        r_psg [1:POLY_TERMS];
    t_acc        r_acc [1:POLY_TERMS];
    t_ang        r_r;
    logic signed [OUT_WIDTH-1:0] r_angle;

    logic        n_neg;
    t_q30        n_xp;
    t_q30        n_omx;
    t_rem        n_rem [1:SQ_STAGES-1];
    t_q30        n_root[1:SQ_STAGES];
    t_prd        n_prd [1:POLY_TERMS];
    logic        n_psg [1:POLY_TERMS];
    t_acc        n_acc [1:POLY_TERMS];
    t_ang        n_r;
    logic [OUT_WIDTH-1:0] n_angle;

    function automatic logic [31:0] f_mag(input t_acc a);
        t_acc na;
        na = -a;
        return a[32] ? na[31:0] : a[31:0];
    endfunction

    // round to nearest, ties away from zero, then restore the sign
    function automatic t_acc f_rnd(input t_prd p, input logic sgn);
        logic [63:0] sum;
        logic [32:0] m;
        sum = {1'b0, p} + 64'(1 << 29);
        m   = sum[62:30];
        return sgn ? $signed(~m + 33'd1) : $signed(m);
    endfunction

    // a stage takes new data when it is empty or its successor takes its data
    always_comb begin
        w_en[LAST] = !r_vld[LAST] || o_rsp.ready;
        for (int s = LAST - 1; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign i_req.ready = w_en[0];
    assign o_rsp.valid = r_vld[LAST];
    assign o_rsp.angle = r_angle;

    // operand fold: sign, magnitude, clamp at one
    always_comb begin
        logic [IN_WIDTH:0] sx;
        logic [IN_WIDTH:0] mag;
        logic [32:0]       x30;
        n_neg = i_req.value[IN_WIDTH-1];
        sx    = {i_req.value[IN_WIDTH-1], i_req.value};
        mag   = n_neg ? (~sx + 1'b1) : sx;
        x30   = 33'(mag) << (32 - IN_WIDTH);
        if (x30 >= 33'(Q30_ONE)) begin
            n_xp  = Q30_ONE;
            n_omx = '0;
        end else begin
            n_xp  = x30[30:0];
            n_omx = Q30_ONE - x30[30:0];
        end
    end

    // digit-by-digit square root of omx * 2^30, two leading zero pairs pad it to 33 steps
    always_comb begin
        t_rem        rem;
        t_q30        root;
        logic [65:0] rad;
        logic [32:0] trial;
        int          j;
        for (int s = 1; s <= SQ_STAGES; s++) begin
            if (s == 1) begin
                rem  = '0;
                root = '0;
            end else begin
                rem  = (s - 1 <= SQ_STAGES - 1) ? r_rem[s-1] : '0;
                root = r_root[s-1];
            end
            rad = {5'b0, r_omx[s-1], 30'b0};
            for (int q = 0; q < SQ_ITERS; q++) begin
                j     = SQ_ITERS * (s - 1) + q;
                rem   = {rem[31:0], rad[65-2*j -: 2]};
                trial = {root, 2'b01};
                if (rem >= {1'b0, trial}) begin
                    rem  = rem - {1'b0, trial};
                    root = {root[29:0], 1'b1};
                end else begin
                    root = {root[29:0], 1'b0};
                end
            end
            if (s <= SQ_STAGES - 1) begin
                n_rem[s] = rem;
            end
            n_root[s] = root;
        end
    end

    // horner: odd stages multiply; even ones round, add the next coefficient; 16 only rounds
    always_comb begin
        n_prd[1] = {31'b0, f_mag(COEF[0])} * {32'b0, r_xp[0]};
        n_psg[1] = COEF[0][32];
        for (int k = 2; k < POLY_TERMS; k++) begin
            n_prd[k] = {31'b0, f_mag(r_acc[k-1])} * {32'b0, r_xp[2*k-2]};
            n_psg[k] = r_acc[k-1][32];
        end
        n_prd[POLY_TERMS] = {31'b0, f_mag(r_acc[POLY_TERMS-1])} * {32'b0, r_root[ROOT_LAST]};
        n_psg[POLY_TERMS] = r_acc[POLY_TERMS-1][32];

        for (int k = 1; k < POLY_TERMS; k++) begin
            n_acc[k] = f_rnd(r_prd[k], r_psg[k]) + COEF[k];
        end
        n_acc[POLY_TERMS] = f_rnd(r_prd[POLY_TERMS], r_psg[POLY_TERMS]);
    end

    // reflection by op and sign
    always_comb begin
        t_ang t;
        t = 35'(r_acc[POLY_TERMS]);
        case (r_op[LAST-2])
            OP_ACOS: n_r = r_neg[LAST-2] ? (Q30_PI - t) : t;
            OP_ASIN: n_r = r_neg[LAST-2] ? (t - Q30_HALF_PI) : (Q30_HALF_PI - t);
            default: n_r = '0;
        endcase
    end

    // output rounding and saturation
    always_comb begin
        t_ang        nr;
        logic [33:0] rmag;
        logic [34:0] rsum;
        logic [34:0] qmag;
        nr   = -r_r;
        rmag = r_r[34] ? nr[33:0] : r_r[33:0];
        rsum = {1'b0, rmag} + 35'(1 << (OUT_SHIFT - 1));
        qmag = rsum >> OUT_SHIFT;
        if (!r_r[34]) begin
            n_angle = (qmag > 35'(LIM_POS)) ? LIM_POS : OUT_WIDTH'(qmag);
        end else begin
            n_angle = (qmag > 35'(LIM_NEG)) ? LIM_NEG : OUT_WIDTH'(~qmag + 35'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_req.valid;
            for (int s = 1; s <= LAST; s++) begin
                if (w_en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_op[0]  <= i_req.op;
            r_neg[0] <= n_neg;
            r_xp[0]  <= n_xp;
            r_omx[0] <= n_omx;
        end
        for (int s = 1; s <= LAST - 1; s++) begin
            if (w_en[s]) begin
                r_op[s]  <= r_op[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
        for (int s = 1; s <= 12; s++) begin
            if (w_en[s]) r_xp[s] <= r_xp[s-1];
        end
        for (int s = 1; s <= SQ_STAGES - 1; s++) begin
            if (w_en[s]) begin
                r_omx[s] <= r_omx[s-1];
                r_rem[s] <= n_rem[s];
            end
        end
        for (int s = 1; s <= SQ_STAGES; s++) begin
            if (w_en[s]) r_root[s] <= n_root[s];
        end
        for (int s = SQ_STAGES + 1; s <= ROOT_LAST; s++) begin
            if (w_en[s]) r_root[s] <= r_root[s-1];
        end
        for (int k = 1; k <= POLY_TERMS; k++) begin
            if (w_en[2*k-1]) begin
                r_prd[k] <= n_prd[k];
                r_psg[k] <= n_psg[k];
            end
            if (w_en[2*k]) r_acc[k] <= n_acc[k];
        end
        if (w_en[LAST-1]) r_r <= n_r;
        if (w_en[LAST]) r_angle <= $signed(n_angle);
    end

    // a drained output stage lets the whole pipe advance
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAST] |-> i_req.ready)
        else $error("request refused with an empty output stage");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ROOT_LAST] |-> (r_root[ROOT_LAST] <= Q30_ONE))
        else $error("square root above one");

    a_t_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2*POLY_TERMS] |-> !r_acc[POLY_TERMS][32])
        else $error("folded angle negative");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |-> (r_angle >= ANGLE_MIN && r_angle <= ANGLE_MAX))
        else $error("angle outside -pi/2..pi");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import asacu_pkg::*;

    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  MAX_WAIT       = 13;

    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint          HALF_PI_Q30 = 64'sd1686629713;
    localparam longint          PI_Q30      = 64'sd3373259426;

    // minimax acos polynomial, highest degree first, Q1.30
    localparam longint ACOS_POLY [0:7] = '{
        -64'sd1355589,   64'sd7161955,   -64'sd18348235,  64'sd33169905,
        -64'sd53874249,  64'sd95540460,  -64'sd230423709, 64'sd1686629690
    };

    logic clk;
    logic rst_n;

    asacu_req_if req_if ();
    asacu_rsp_if rsp_if ();

    arcsine_arccosine_unit_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic signed [OUT_WIDTH-1:0] expected_angles [$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  tx_burst    = 1'b0;
    bit  rx_burst    = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // rnd(a * b / 2^30), ties away from zero
    function automatic longint scale_q30(input longint a, input longint unsigned b);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (a < 0) ? longint'(-a) : a;
        prod = (mag * b + (64'd1 << 29)) >> 30;
        return (a < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w >>= 2;
        while (bit_w != 0) begin
            if (n >= res + bit_w) begin
                n   = n - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] predict_angle(
        input logic op, input logic signed [IN_WIDTH-1:0] value);
        longint unsigned raw, mag, x30, xp, omx, root, m;
        longint acc, t, r, q;
        bit neg;
        int sh;
        sh  = 33 - OUT_WIDTH;
        raw = longint'(value) & ((64'd1 << IN_WIDTH) - 1);
        neg = value[IN_WIDTH-1];
        mag = neg ? (64'd1 << IN_WIDTH) - raw : raw;
        x30 = mag << (32 - IN_WIDTH);
        // magnitude at or above one: sqrt term vanishes
        if (x30 >= ONE_Q30) begin
            xp  = ONE_Q30;
            omx = 0;
        end else begin
            xp  = x30;
            omx = ONE_Q30 - x30;
        end
        root = floor_sqrt(omx << 30);
        acc  = ACOS_POLY[0];
        for (int i = 1; i < 8; i++)
            acc = scale_q30(acc, xp) + ACOS_POLY[i];
        t = scale_q30(acc, root);
        if (op == OP_ACOS)
            r = neg ? PI_Q30 - t : t;
        else
            r = neg ? t - HALF_PI_Q30 : HALF_PI_Q30 - t;
        m = (r < 0) ? longint'(-r) : r;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        q = (r < 0) ? -longint'(m) : longint'(m);
        if (q > (64'sd1 << (OUT_WIDTH - 1)) - 1) q = (64'sd1 << (OUT_WIDTH - 1)) - 1;
        if (q < -(64'sd1 << (OUT_WIDTH - 1)))    q = -(64'sd1 << (OUT_WIDTH - 1));
        return q[OUT_WIDTH-1:0];
    endfunction

    task automatic send_request(input logic op, input logic signed [IN_WIDTH-1:0] value);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.value <= value;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        expected_angles.push_back(predict_angle(op, value));
    endtask

    task automatic wait_results_done();
        req_if.valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge clk);
    endtask

    function automatic logic random_op();
        return $urandom_range(0, 1) ? OP_ACOS : OP_ASIN;
    endfunction

    function automatic void shuffle_idling();
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
    endfunction

    // extremes, zero, unit magnitude, just past unit, most negative
    task automatic test_directed();
        logic signed [IN_WIDTH-1:0] corner [0:11];
        corner = '{16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 16'sd16383,
                   -16'sd16383, 16'sd16385, -16'sd16385, 16'sd32767, -16'sd32768,
                   16'sd11585};
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        foreach (corner[i]) begin
            send_request(OP_ASIN, corner[i]);
            send_request(OP_ACOS, corner[i]);
        end
    endtask

    // arguments inside [-1, 1], where the polynomial does real work
    task automatic test_random_in_range(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 48 == 0) shuffle_idling();
            send_request(random_op(), IN_WIDTH'($signed($urandom_range(0, 32768)) - 16384));
        end
    endtask

    // any bit pattern, including clamped magnitudes
    task automatic test_random_full_range(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 48 == 0) shuffle_idling();
            send_request(random_op(), IN_WIDTH'($urandom()));
        end
    endtask

    task automatic test_pause_until_drained(input int count);
        test_random_in_range(count);
        wait_results_done();
        test_random_in_range(count);
    endtask

    initial begin
        req_if.valid <= 1'b0;
        req_if.op    <= OP_ASIN;
        req_if.value <= '0;
        rst_n        <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_in_range(420);
        test_pause_until_drained(60);
        test_random_full_range(330);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        test_random_in_range(60);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // response ready: random stall before each request result
    initial begin : rsp_ready_drive
        int stall;
        rsp_if.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        logic signed [OUT_WIDTH-1:0] want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_angles.size() == 0) begin
                $error("unexpected result: angle %0d", rsp_if.angle);
                error_count++;
            end else begin
                want = expected_angles.pop_front();
                if (rsp_if.angle !== want) begin
                    $error("angle mismatch: expected %0d, actual %0d", want, rsp_if.angle);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

`default_nettype wire
